[hw/rtl/pidvil_pkg.sv]
// ----------------------------------------------------------------------------
// pidvil_pkg
// Shared constants for the positional PID controller: field widths,
// register indexes and fixed-point settings.
// ----------------------------------------------------------------------------
package pidvil_pkg;

  // Field and register widths
  localparam int SAMPLE_W = 16;   // target, measured
  localparam int ERR_W    = 17;   // target - measured
  localparam int DIFF_W   = 18;   // error - previous error
  localparam int GAIN_W   = 16;   // Q8.8 gains
  localparam int BOUND_W  = 16;   // separation bounds
  localparam int ILIM_W   = 23;   // integral limit
  localparam int OLIM_W   = 15;   // output limit
  localparam int ISUM_W   = 24;   // integral sum
  localparam int WEIGHT_W = 17;   // Q0.16 weight, 0..65536
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Integral separation on (1) or off (0)
  localparam bit SEPARATION_ON = 1'b1;
  // Fraction bits of the gains; the weight adds another 16
  localparam int GAIN_FRAC = 8;
  localparam int OUT_SHIFT = 16 + GAIN_FRAC;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_UPPER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_LOWER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIM    = 3'd6;

  // Full weight, 1.0 in Q0.16
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

endpackage

[hw/rtl/pid_variable_integral_limited.sv]
// ----------------------------------------------------------------------------
// pid_variable_integral_limited
// Positional PID with variable-weight integral separation, integral clamp
// and output clamp, built around one shared multiplier and a bit-serial
// divider under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input request on s_tvalid/s_tready/s_tdata carries target and measured.
//   Result request on m_tvalid/m_tready/m_tdata carries the drive value.
//   Gains, separation bounds and limits are written through cfg_we, cfg_index
//   and cfg_data; the user must do so only while idle (not enforced); bad indexes are ignored.
// Timing:
//   s_tready is high only while the sequencer is idle, so a new item is
//   taken only after the previous result has been loaded into the output
//   register. The restoring divider runs only when the integral weight falls
//   in the middle band, one quotient bit per cycle for a 17-bit quotient. The five products
//   go one per cycle through a single 25x18 multiplier.
// Reset:
//   rst clears the integral sum and previous error, loads the register
//   reset values and drops m_tvalid.
// Stall:
//   A finished result sits in the output register; the next item may be
//   accepted meanwhile, but its result waits until the held one is taken.
// ----------------------------------------------------------------------------
module pid_variable_integral_limited (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic                               cfg_we,
  input  logic [pidvil_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pidvil_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] target, [31:16] measured
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [15:0] drive
);
  import pidvil_pkg::*;

  localparam int ACC_W  = 58;
  localparam int MA_W   = 25;
  localparam int MB_W   = 18;
  localparam int PROD_W = MA_W + MB_W;
  localparam int PIA_W  = GAIN_W + ISUM_W;  // ki * integral
  localparam int LO_W   = 20;               // low split of ki * integral

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ERR   = 4'd1;
  localparam logic [3:0] ST_SEP   = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_CLAMP = 4'd4;
  localparam logic [3:0] ST_M_PE  = 4'd5;
  localparam logic [3:0] ST_M_DE  = 4'd6;
  localparam logic [3:0] ST_M_IA  = 4'd7;
  localparam logic [3:0] ST_M_WL  = 4'd8;
  localparam logic [3:0] ST_M_WH  = 4'd9;
  localparam logic [3:0] ST_M_FIN = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  // Configuration registers
  logic signed [GAIN_W-1:0] prop_gain, integ_gain, deriv_gain;
  logic [BOUND_W-1:0]       sep_upper, sep_lower;
  logic [ILIM_W-1:0]        integ_limit;
  logic [OLIM_W-1:0]        out_limit;

  // State and datapath registers
  logic [3:0]               state;
  logic signed [ISUM_W-1:0] integral_sum;
  logic signed [ERR_W-1:0]  prev_error;
  logic signed [SAMPLE_W-1:0] target, measured;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] err_diff;
  logic signed [ISUM_W:0]   acc_raw;
  logic [WEIGHT_W-1:0]      weight;
  logic [BOUND_W-1:0]       den;
  logic [WEIGHT_W-1:0]      div_rem;
  logic [WEIGHT_W-1:0]      div_q;
  logic [4:0]               div_cnt;
  logic signed [PROD_W-1:0] prod;
  logic signed [PIA_W-1:0]  pia;
  logic signed [ACC_W-1:0]  sacc;
  logic [15:0]              drive;

  // Combinational helpers
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic [ERR_W-1:0]         mag;
  logic [WEIGHT_W:0]        trial;
  logic                     trial_ge;
  logic [WEIGHT_W:0]        trial_sub;
  logic signed [ISUM_W:0]   lim_pos;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  dshift;
  logic signed [ACC_W-1:0]  olim_pos;
  logic                     out_free;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = drive;
  assign out_free = !m_tvalid || m_tready;

  // Error magnitude
  assign mag = err[ERR_W-1] ? ERR_W'(-err) : err;

  // Divider trial: first step compares without shifting
  assign trial     = (div_cnt == 5'd16) ? {1'b0, div_rem} : {div_rem, 1'b0};
  assign trial_ge  = trial >= {2'b00, den};
  assign trial_sub = trial - {2'b00, den};

  // Clamp bounds
  assign lim_pos  = {2'b00, integ_limit};
  assign olim_pos = {{(ACC_W-OLIM_W){1'b0}}, out_limit};
  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign dshift   = sacc >>> OUT_SHIFT;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_M_PE: begin
        mul_a = MA_W'(prop_gain);
        mul_b = MB_W'(err);
      end
      ST_M_DE: begin
        mul_a = MA_W'(deriv_gain);
        mul_b = err_diff;
      end
      ST_M_IA: begin
        mul_a = MA_W'(integral_sum);
        mul_b = MB_W'(integ_gain);
      end
      ST_M_WL: begin
        mul_a = {{(MA_W-LO_W){1'b0}}, prod[LO_W-1:0]};
        mul_b = {1'b0, weight};
      end
      ST_M_WH: begin
        // high part keeps the sign of ki * integral
        mul_a = MA_W'($signed(pia[PIA_W-1:LO_W]));
        mul_b = {1'b0, weight};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      sep_upper   <= '1;
      sep_lower   <= '0;
      integ_limit <= '1;
      out_limit   <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  prop_gain   <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain  <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain  <= cfg_data[GAIN_W-1:0];
        REG_SEP_UPPER:  sep_upper   <= cfg_data[BOUND_W-1:0];
        REG_SEP_LOWER:  sep_lower   <= cfg_data[BOUND_W-1:0];
        REG_INTEG_LIM:  integ_limit <= cfg_data[ILIM_W-1:0];
        REG_OUT_LIM:    out_limit   <= cfg_data[OLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      integral_sum <= '0;
      prev_error   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // Result valid: set when a result is loaded, cleared when taken
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_ERR;
          end
        end
        ST_ERR: begin
          state <= ST_SEP;
        end
        ST_SEP: begin
          prev_error <= err;
          if (SEPARATION_ON && (mag > {1'b0, sep_upper})) begin
            state <= ST_CLAMP;
          end else if (!SEPARATION_ON || (mag < {1'b0, sep_lower})) begin
            state <= ST_CLAMP;
          end else if (sep_upper == sep_lower) begin
            state <= ST_CLAMP;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_cnt == 5'd0) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          if (acc_raw > lim_pos) begin
            integral_sum <= lim_pos[ISUM_W-1:0];
          end else if (acc_raw < -lim_pos) begin
            integral_sum <= ISUM_W'(-lim_pos);
          end else begin
            integral_sum <= acc_raw[ISUM_W-1:0];
          end
          state <= ST_M_PE;
        end
        ST_M_PE:  state <= ST_M_DE;
        ST_M_DE:  state <= ST_M_IA;
        ST_M_IA:  state <= ST_M_WL;
        ST_M_WL:  state <= ST_M_WH;
        ST_M_WH:  state <= ST_M_FIN;
        ST_M_FIN: state <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        target   <= s_tdata[SAMPLE_W-1:0];
        measured <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
      end
      ST_ERR: begin
        err <= ERR_W'(target) - ERR_W'(measured);
      end
      ST_SEP: begin
        err_diff <= DIFF_W'(err) - DIFF_W'(prev_error);
        den      <= sep_upper - sep_lower;
        div_rem  <= {1'b0, sep_upper - mag[BOUND_W-1:0]};
        div_q    <= '0;
        div_cnt  <= 5'd16;
        // Integral skipped above the upper bound
        if (SEPARATION_ON && (mag > {1'b0, sep_upper})) begin
          acc_raw <= (ISUM_W+1)'(integral_sum);
          weight  <= '0;
        end else begin
          acc_raw <= (ISUM_W+1)'(integral_sum) + (ISUM_W+1)'(err);
          if (!SEPARATION_ON || (mag < {1'b0, sep_lower})) begin
            weight <= WEIGHT_ONE;
          end else begin
            weight <= '0;
          end
        end
      end
      ST_DIV: begin
        // One restoring quotient bit per cycle
        div_rem <= trial_ge ? trial_sub[WEIGHT_W-1:0] : trial[WEIGHT_W-1:0];
        div_q   <= {div_q[WEIGHT_W-2:0], trial_ge};
        div_cnt <= div_cnt - 5'd1;
        if (div_cnt == 5'd0) begin
          weight <= {div_q[WEIGHT_W-2:0], trial_ge};
        end
      end
      ST_M_DE: begin
        sacc <= prod_ext;                       // kp * e
      end
      ST_M_IA: begin
        sacc <= sacc + prod_ext;                // + kd * (e - prev)
      end
      ST_M_WL: begin
        pia  <= prod[PIA_W-1:0];                // ki * integral
        sacc <= sacc <<< 16;
      end
      ST_M_WH: begin
        sacc <= sacc + prod_ext;                // + low part * w
      end
      ST_M_FIN: begin
        sacc <= sacc + (prod_ext <<< LO_W);     // + high part * w
      end
      ST_OUT: begin
        if (out_free) begin
          if (dshift > olim_pos) begin
            drive <= olim_pos[15:0];
          end else if (dshift < -olim_pos) begin
            drive <= 16'(-olim_pos);
          end else begin
            drive <= dshift[15:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule
